### rtl/core/bitmap_frame_allocator_defines.svh
// Assertion helpers for the bitmap frame allocator.
// Each macro expands to one labeled concurrent assertion that is disabled
// while the synchronous active-low reset is held.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap frame allocator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap frame allocator assertion failed");

`endif

### rtl/core/bfa_pkg.sv
package bfa_pkg;

    localparam int FRAME_W   = 20;
    localparam int CNT_W     = 16;
    localparam int OFF_W     = 21;  // frame offsets and range ends, with one bit of headroom
    localparam int BIDX_W    = OFF_W - 3;
    localparam int CFG_IDX_W = 3;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    typedef logic [OFF_W-1:0]  t_off;
    typedef logic [BIDX_W-1:0] t_bidx;

    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREALLOC_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_COUNT = 3'd4;

    localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 16'h8000;
    localparam logic [7:0]       BYTE_FULL       = 8'hFF;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT_SETUP,
        S_INIT_SWEEP,
        S_ALLOC_SCAN,
        S_REL_CHK,
        S_REL_WR,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_FILL,
        OP_SETBIT,
        OP_CLRBIT
    } t_op;

    typedef struct packed {
        logic [7:0] wdata;
        logic       found;
        logic       past_end;
        logic [2:0] bit_sel;
    } t_byte_res;

    // Bits of byte idx whose frame offset lies below bound.
    function automatic logic [7:0] f_lt_mask(input t_bidx idx, input t_off bound);
        logic [7:0] m;
        m = '0;
        if (idx < bound[OFF_W-1:3]) begin
            m = BYTE_FULL;
        end else if (idx == bound[OFF_W-1:3]) begin
            m = 8'((9'd1 << bound[2:0]) - 9'd1);
        end
        return m;
    endfunction

    // Lowest set bit of an eight-bit vector, zero when none is set.
    function automatic logic [2:0] f_low_bit(input logic [7:0] v);
        logic [2:0] sel;
        sel = '0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                sel = 3'(i);
            end
        end
        return sel;
    endfunction

endpackage

### rtl/core/bfa_bitmap_mem.sv
module bfa_bitmap_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bfa_byte_unit.sv
// Works on one bitmap byte per cycle: clearing, fill masks, free-bit search and bit updates.
module bfa_byte_unit (
    input  bfa_pkg::t_op       i_op,
    input  bfa_pkg::t_bidx     i_idx,
    input  logic [7:0]         i_rdata,
    input  bfa_pkg::t_off      i_bound_a,
    input  bfa_pkg::t_off      i_bound_lo,
    input  bfa_pkg::t_off      i_bound_hi,
    input  logic [2:0]         i_bit,
    output bfa_pkg::t_byte_res o_res
);

    always_comb begin
        logic [7:0] mask_a;
        logic [7:0] mask_lo;
        logic [7:0] mask_hi;
        logic [7:0] free_bits;
        mask_a    = bfa_pkg::f_lt_mask(i_idx, i_bound_a);
        mask_lo   = bfa_pkg::f_lt_mask(i_idx, i_bound_lo);
        mask_hi   = bfa_pkg::f_lt_mask(i_idx, i_bound_hi);
        free_bits = ~i_rdata & mask_a;

        o_res          = '0;
        o_res.bit_sel  = bfa_pkg::f_low_bit(free_bits);
        o_res.found    = |free_bits;
        o_res.past_end = (mask_a == 8'd0);

        unique case (i_op)
            bfa_pkg::OP_CLEAR:  o_res.wdata = 8'd0;
            bfa_pkg::OP_FILL:   o_res.wdata = mask_a | (~mask_lo & mask_hi);
            bfa_pkg::OP_SETBIT: o_res.wdata = i_rdata | (8'd1 << o_res.bit_sel);
            bfa_pkg::OP_CLRBIT: o_res.wdata = i_rdata & ~(8'd1 << i_bit);
        endcase
    end

endmodule

### rtl/core/bitmap_frame_allocator.sv
// Channel   | Valid       | Stall        | Payload
// ----------+-------------+--------------+------------------------------------
// command   | i_in_valid  | o_in_stall   | i_cmd, i_frame_index
// result    | o_out_valid | i_out_stall  | o_status, o_granted_frame
// config    | i_cfg_we    | (none)       | i_cfg_index, i_cfg_data
//
// One command at a time; the byte-wide memory port and the shared byte unit
// handle one bitmap byte per cycle. Init sweeps every bitmap byte, alloc scans
// until a free frame or the pool end, release checks the frame and, unless
// refused, clears its bit, and the unused command goes straight to the result.
// After reset a clearing pass over all BITMAP_BYTES bytes stalls commands but
// takes configuration writes. A stalled result beat blocks only a second result.
`include "bitmap_frame_allocator_defines.svh"

module bitmap_frame_allocator #(
    parameter int BITMAP_BYTES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bfa_pkg::FRAME_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bfa_pkg::CMD_W-1:0]       i_cmd,
    input  logic [bfa_pkg::FRAME_W-1:0]     i_frame_index,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bfa_pkg::STATUS_W-1:0]    o_status,
    output logic [bfa_pkg::FRAME_W-1:0]     o_granted_frame
);

    // Byte address width and a counter width that can also hold BITMAP_BYTES.
    localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int IW = AW + 1;
    localparam bfa_pkg::t_off CAP      = bfa_pkg::OFF_W'(BITMAP_BYTES * 8);
    localparam logic [IW-1:0] LAST_IDX = IW'(BITMAP_BYTES - 1);

    // Configuration registers.
    logic [bfa_pkg::FRAME_W-1:0] r_base_frame;
    logic [bfa_pkg::CNT_W-1:0]   r_frame_count;
    logic [bfa_pkg::CNT_W-1:0]   r_prealloc_count;
    logic [bfa_pkg::FRAME_W-1:0] r_reserved_base;
    logic [bfa_pkg::CNT_W-1:0]   r_reserved_count;

    // Sequencer state and datapath registers.
    bfa_pkg::t_state             r_state, n_state;
    logic [IW-1:0]               r_iss_idx, n_iss_idx;
    logic [IW-1:0]               r_chk_idx, n_chk_idx;
    logic                        r_chk_vld, n_chk_vld;
    logic [bfa_pkg::FRAME_W-1:0] r_frame, n_frame;
    bfa_pkg::t_off               r_rsv_lo, n_rsv_lo;
    bfa_pkg::t_off               r_rsv_hi, n_rsv_hi;
    logic [AW-1:0]               r_rel_addr, n_rel_addr;
    logic [2:0]                  r_rel_bit, n_rel_bit;
    logic [bfa_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [bfa_pkg::FRAME_W-1:0] r_res_grant, n_res_grant;
    logic                        r_out_valid, n_out_valid;
    logic [bfa_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [bfa_pkg::FRAME_W-1:0] r_out_grant, n_out_grant;

    // Memory and byte unit hookup.
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;
    logic [7:0]                  mem_rdata;
    bfa_pkg::t_op                unit_op;
    bfa_pkg::t_bidx              unit_idx;
    bfa_pkg::t_off               unit_bound_a;
    bfa_pkg::t_byte_res          bres;

    // Handshakes.
    logic in_acc;
    logic out_acc;
    logic slot_free;

    // Range arithmetic, all in offset width so that sums never wrap.
    bfa_pkg::t_off               base_ext;
    bfa_pkg::t_off               rb_ext;
    bfa_pkg::t_off               fr_ext;
    bfa_pkg::t_off               rsv_end;
    bfa_pkg::t_off               pool_n;
    bfa_pkg::t_off               setup_lo;
    bfa_pkg::t_off               setup_hi;
    logic                        rel_refused;
    logic [bfa_pkg::FRAME_W-1:0] rel_off;

    // Terms checked by the assertions below.
    logic chk_err_beat;
    logic chk_sweeping;
    logic chk_resp_load;
    logic chk_idle_beat;

    assign o_in_stall  = (r_state != bfa_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    // The output register can take a new result this cycle.
    assign slot_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_frame = r_out_grant;

    assign base_ext = bfa_pkg::OFF_W'(r_base_frame);
    assign rb_ext   = bfa_pkg::OFF_W'(r_reserved_base);
    assign fr_ext   = bfa_pkg::OFF_W'(r_frame);
    assign rsv_end  = rb_ext + bfa_pkg::OFF_W'(r_reserved_count);
    // Pool size is limited to what the bitmap can hold.
    assign pool_n   = (bfa_pkg::OFF_W'(r_frame_count) < CAP) ?
                      bfa_pkg::OFF_W'(r_frame_count) : CAP;

    // The reserved range is taken relative to the base frame; the part
    // below the base frame is dropped. Clipping at the top of the bitmap
    // happens naturally because the sweep never passes the last byte.
    always_comb begin
        setup_lo = '0;
        setup_hi = '0;
        if (rsv_end > base_ext) begin
            setup_lo = (rb_ext > base_ext) ? (rb_ext - base_ext) : '0;
            setup_hi = rsv_end - base_ext;
        end
    end

    // A release is refused for any frame in the reserved range, even one
    // outside the pool, and for any frame outside the pool.
    assign rel_refused = ((fr_ext >= rb_ext) && (fr_ext < rsv_end)) ||
                         (fr_ext < base_ext) || (fr_ext >= (base_ext + pool_n));
    assign rel_off     = r_frame - r_base_frame;

    bfa_bitmap_mem #(
        .DEPTH (BITMAP_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (bres.wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bfa_byte_unit u_unit (
        .i_op       (unit_op),
        .i_idx      (unit_idx),
        .i_rdata    (mem_rdata),
        .i_bound_a  (unit_bound_a),
        .i_bound_lo (r_rsv_lo),
        .i_bound_hi (r_rsv_hi),
        .i_bit      (r_rel_bit),
        .o_res      (bres)
    );

    // Configuration writes are taken in any state; indexes past the last
    // register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_frame     <= '0;
            r_frame_count    <= bfa_pkg::FRAME_COUNT_RST;
            r_prealloc_count <= '0;
            r_reserved_base  <= '0;
            r_reserved_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bfa_pkg::CFG_BASE_FRAME:     r_base_frame     <= i_cfg_data;
                bfa_pkg::CFG_FRAME_COUNT:    r_frame_count    <= i_cfg_data[bfa_pkg::CNT_W-1:0];
                bfa_pkg::CFG_PREALLOC_COUNT: r_prealloc_count <= i_cfg_data[bfa_pkg::CNT_W-1:0];
                bfa_pkg::CFG_RESERVED_BASE:  r_reserved_base  <= i_cfg_data;
                bfa_pkg::CFG_RESERVED_COUNT: r_reserved_count <= i_cfg_data[bfa_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfa_pkg::S_CLEAR: begin
                if (r_iss_idx == LAST_IDX) begin
                    n_state = bfa_pkg::S_IDLE;
                end
            end
            bfa_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (i_cmd)
                        bfa_pkg::CMD_INIT:    n_state = bfa_pkg::S_INIT_SETUP;
                        bfa_pkg::CMD_ALLOC:   n_state = bfa_pkg::S_ALLOC_SCAN;
                        bfa_pkg::CMD_RELEASE: n_state = bfa_pkg::S_REL_CHK;
                        bfa_pkg::CMD_NOP:     n_state = bfa_pkg::S_RESP;
                    endcase
                end
            end
            bfa_pkg::S_INIT_SETUP: n_state = bfa_pkg::S_INIT_SWEEP;
            bfa_pkg::S_INIT_SWEEP: begin
                if (r_iss_idx == LAST_IDX) begin
                    n_state = bfa_pkg::S_RESP;
                end
            end
            bfa_pkg::S_ALLOC_SCAN: begin
                if (r_chk_vld && (bres.found || bres.past_end)) begin
                    n_state = bfa_pkg::S_RESP;
                end
            end
            bfa_pkg::S_REL_CHK: begin
                n_state = rel_refused ? bfa_pkg::S_RESP : bfa_pkg::S_REL_WR;
            end
            bfa_pkg::S_REL_WR: n_state = bfa_pkg::S_RESP;
            bfa_pkg::S_RESP: begin
                if (slot_free) begin
                    n_state = bfa_pkg::S_IDLE;
                end
            end
            default: n_state = bfa_pkg::S_IDLE;
        endcase
    end

    // Datapath control: memory port, byte unit selection and register loads.
    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = r_iss_idx[AW-1:0];
        mem_raddr    = r_iss_idx[AW-1:0];
        unit_op      = bfa_pkg::OP_CLEAR;
        unit_idx     = bfa_pkg::BIDX_W'(r_iss_idx);
        unit_bound_a = pool_n;

        n_iss_idx    = r_iss_idx;
        n_chk_idx    = r_chk_idx;
        n_chk_vld    = r_chk_vld;
        n_frame      = r_frame;
        n_rsv_lo     = r_rsv_lo;
        n_rsv_hi     = r_rsv_hi;
        n_rel_addr   = r_rel_addr;
        n_rel_bit    = r_rel_bit;
        n_res_status = r_res_status;
        n_res_grant  = r_res_grant;
        // A result beat leaves the output register when it is taken.
        n_out_valid  = r_out_valid && !out_acc;
        n_out_status = r_out_status;
        n_out_grant  = r_out_grant;

        unique case (r_state)
            bfa_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                n_iss_idx = r_iss_idx + IW'(1);
            end
            bfa_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_frame      = i_frame_index;
                    n_iss_idx    = '0;
                    n_chk_vld    = 1'b0;
                    n_res_status = bfa_pkg::STATUS_OK;
                    n_res_grant  = '0;
                end
            end
            bfa_pkg::S_INIT_SETUP: begin
                n_rsv_lo = setup_lo;
                n_rsv_hi = setup_hi;
            end
            bfa_pkg::S_INIT_SWEEP: begin
                // Each byte gets the preallocated prefix and the reserved range.
                unit_op      = bfa_pkg::OP_FILL;
                unit_bound_a = bfa_pkg::OFF_W'(r_prealloc_count);
                mem_we       = 1'b1;
                n_iss_idx    = r_iss_idx + IW'(1);
            end
            bfa_pkg::S_ALLOC_SCAN: begin
                // Reads are issued one byte ahead of the byte being checked.
                unit_op   = bfa_pkg::OP_SETBIT;
                unit_idx  = bfa_pkg::BIDX_W'(r_chk_idx);
                n_iss_idx = r_iss_idx + IW'(1);
                n_chk_idx = r_iss_idx;
                n_chk_vld = 1'b1;
                if (r_chk_vld) begin
                    if (bres.found) begin
                        mem_we      = 1'b1;
                        mem_waddr   = r_chk_idx[AW-1:0];
                        n_res_grant = r_base_frame +
                                      bfa_pkg::FRAME_W'({r_chk_idx, bres.bit_sel});
                    end else if (bres.past_end) begin
                        n_res_status = bfa_pkg::STATUS_NO_FREE;
                    end
                end
            end
            bfa_pkg::S_REL_CHK: begin
                if (rel_refused) begin
                    n_res_status = bfa_pkg::STATUS_REFUSED;
                end else begin
                    mem_raddr  = rel_off[AW+2:3];
                    n_rel_addr = rel_off[AW+2:3];
                    n_rel_bit  = rel_off[2:0];
                end
            end
            bfa_pkg::S_REL_WR: begin
                unit_op   = bfa_pkg::OP_CLRBIT;
                mem_we    = 1'b1;
                mem_waddr = r_rel_addr;
            end
            bfa_pkg::S_RESP: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_grant  = r_res_grant;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfa_pkg::S_CLEAR;
            r_iss_idx   <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iss_idx   <= n_iss_idx;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_frame      <= n_frame;
        r_rsv_lo     <= n_rsv_lo;
        r_rsv_hi     <= n_rsv_hi;
        r_rel_addr   <= n_rel_addr;
        r_rel_bit    <= n_rel_bit;
        r_res_status <= n_res_status;
        r_res_grant  <= n_res_grant;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
    end

    assign chk_err_beat  = o_out_valid && (o_status != bfa_pkg::STATUS_OK);
    assign chk_sweeping  = (r_state == bfa_pkg::S_CLEAR) || (r_state == bfa_pkg::S_INIT_SWEEP);
    assign chk_resp_load = (r_state == bfa_pkg::S_RESP) && slot_free;
    assign chk_idle_beat = o_out_valid && (r_state == bfa_pkg::S_IDLE);

    // An accepted command keeps the block busy in the following cycle.
    `BFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall)
    // Only a successful allocation carries a nonzero frame.
    `BFA_ASSERT_IMPL(a_grant_only_on_ok, i_clk, i_rst_n, chk_err_beat, o_granted_frame == '0)
    // Clearing and init sweeps never address past the last bitmap byte.
    `BFA_ASSERT_IMPL(a_sweep_in_range, i_clk, i_rst_n, chk_sweeping, r_iss_idx <= LAST_IDX)
    // A finished command always shows up as a result beat.
    `BFA_ASSERT_NEXT(a_result_loads_output, i_clk, i_rst_n, chk_resp_load, chk_idle_beat)

endmodule
